[design/des_block_cipher_ede_defines.svh]
// ---------------------------------------------------------------------------
// DES EDE assertion macros
// Shared concurrent assertion forms for the cipher design.
// ---------------------------------------------------------------------------
`ifndef DES_BLOCK_CIPHER_EDE_DEFINES_SVH
`define DES_BLOCK_CIPHER_EDE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/des_pkg.sv]
// ---------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes, key schedule and round function for DES.
// ---------------------------------------------------------------------------
package des_pkg;

    localparam int unsigned NUM_ROUNDS = 16;
    localparam int unsigned NUM_PASSES = 3;
    localparam int unsigned NUM_STAGES = NUM_ROUNDS * NUM_PASSES;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KEY_ONE   = 3'd0,
        REG_KEY_TWO   = 3'd1,
        REG_KEY_THREE = 3'd2,
        REG_DECRYPT   = 3'd3,
        REG_TRIPLE    = 3'd4
    } t_reg_index;

    localparam int T_IP [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
        64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam int T_FP [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
        37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam int T_E [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam int T_P [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam int T_PC1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam int T_PC2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    // Total left rotation of C and D after each round.
    localparam int T_CUM_ROT [16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

    localparam logic [3:0] T_S [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64-T_IP[i]];
        return y;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64-T_FP[i]];
        return y;
    endfunction

    // Subkey of a given round (0..15) from a 64-bit key; pure wiring.
    function automatic logic [47:0] subkey(input logic [63:0] key, input int rnd);
        logic [55:0] t;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cc;
        logic [55:0] dd;
        logic [55:0] cd;
        logic [47:0] k;
        for (int i = 0; i < 56; i++) t[55-i] = key[64-T_PC1[i]];
        cc = {t[55:28], t[55:28]} >> (28 - T_CUM_ROT[rnd]);
        dd = {t[27:0], t[27:0]} >> (28 - T_CUM_ROT[rnd]);
        c = cc[27:0];
        d = dd[27:0];
        cd = {c, d};
        for (int i = 0; i < 48; i++) k[47-i] = cd[56-T_PC2[i]];
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] sk);
        logic [47:0] e;
        logic [5:0]  six;
        logic [31:0] sy;
        logic [31:0] y;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-T_E[i]];
        e = e ^ sk;
        for (int s = 0; s < 8; s++) begin
            six = e[47-6*s -: 6];
            sy[31-4*s -: 4] = T_S[s][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) y[31-i] = sy[32-T_P[i]];
        return y;
    endfunction

endpackage

[design/des_block_cipher_ede.sv]
// ---------------------------------------------------------------------------
// DES / triple DES EDE block cipher, ECB
// Fully unrolled 48-round pipeline with one Feistel round per stage.
// ---------------------------------------------------------------------------
// Channel   Direction  Signals
// input     in         i_valid, o_ready, i_data_block[63:0]
// output    out        o_valid, i_ready, o_result_block[63:0]
// config    in         i_cfg_we, i_cfg_index[2:0], i_cfg_data[63:0]
//
// One word enters every cycle while the output is not stalled; each word passes
// the input IP register and then the 48 round registers on its way to the output.
// Single mode runs the first 16 round stages; later stages pass data through.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset clears all valid bits and configuration registers.
// ---------------------------------------------------------------------------
`include "des_block_cipher_ede_defines.svh"

module des_block_cipher_ede
    import des_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_block,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_key_one;
    logic [63:0] r_key_two;
    logic [63:0] r_key_three;
    logic        r_decrypt;
    logic        r_triple;

    logic        r_v [0:NUM_STAGES];
    logic [31:0] r_l [0:NUM_STAGES];
    logic [31:0] r_r [0:NUM_STAGES];

    logic        advance;
    logic [63:0] ip_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_one   <= '0;
            r_key_two   <= '0;
            r_key_three <= '0;
            r_decrypt   <= 1'b0;
            r_triple    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_KEY_ONE:   r_key_one   <= i_cfg_data;
                REG_KEY_TWO:   r_key_two   <= i_cfg_data;
                REG_KEY_THREE: r_key_three <= i_cfg_data;
                REG_DECRYPT:   r_decrypt   <= i_cfg_data[0];
                REG_TRIPLE:    r_triple    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance = !r_v[NUM_STAGES] || i_ready;
    assign o_ready = advance;
    assign ip_in   = perm_ip(i_data_block);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (advance) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_l[0] <= ip_in[63:32];
            r_r[0] <= ip_in[31:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++) begin : g_round
            localparam int PASS = k / NUM_ROUNDS;
            localparam int RND  = k % NUM_ROUNDS;
            logic        active;
            logic        dir_dec;
            logic [63:0] key_sel;
            logic [47:0] sk_fwd;
            logic [47:0] sk_rev;
            logic [31:0] f_out;
            logic [31:0] n_l;
            logic [31:0] n_r;

            // The middle pass runs the opposite direction of the outer ones.
            assign dir_dec = (PASS == 1) ? !r_decrypt : r_decrypt;
            if (PASS == 0) begin : g_k0
                assign key_sel = (r_triple && r_decrypt) ? r_key_three : r_key_one;
                assign active  = 1'b1;
            end else if (PASS == 1) begin : g_k1
                assign key_sel = r_key_two;
                assign active  = r_triple;
            end else begin : g_k2
                assign key_sel = r_decrypt ? r_key_one : r_key_three;
                assign active  = r_triple;
            end

            assign sk_fwd = subkey(key_sel, RND);
            assign sk_rev = subkey(key_sel, NUM_ROUNDS - 1 - RND);
            assign f_out  = round_f(r_r[k], dir_dec ? sk_rev : sk_fwd);

            always_comb begin
                if (!active) begin
                    n_l = r_l[k];
                    n_r = r_r[k];
                end else if (RND == NUM_ROUNDS - 1 && k != NUM_STAGES - 1 && r_triple) begin
                    // Last round of an inner pass: FP then IP leaves halves swapped,
                    // which cancels the usual round swap.
                    n_l = r_l[k] ^ f_out;
                    n_r = r_r[k];
                end else begin
                    n_l = r_r[k];
                    n_r = r_l[k] ^ f_out;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (advance) begin
                    r_v[k+1] <= r_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (advance) begin
                    r_l[k+1] <= n_l;
                    r_r[k+1] <= n_r;
                end
            end
        end
    endgenerate

    assign o_valid        = r_v[NUM_STAGES];
    assign o_result_block = perm_fp({r_r[NUM_STAGES], r_l[NUM_STAGES]});

    `DES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `DES_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_result_block))
    `DES_ASSERT_NEXT(a_entry_valid, i_clk, i_rst_n, advance, r_v[0] == $past(i_valid))
    `DES_ASSERT_NEXT(a_single_pass_thru, i_clk, i_rst_n, advance && !r_triple, r_l[NUM_STAGES] === $past(r_l[NUM_STAGES-1]))

endmodule

[bench/tb_des_block_cipher_ede.sv]
// ---------------------------------------------------------------------------
// DES / triple DES EDE testbench
// Drives known-answer words and random words through the cipher under many
// key and mode settings, with bursty input and a stalling output, and checks
// every output word in order against its known answer or a behavioral DES model.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_des_block_cipher_ede;
    import des_pkg::*;

    localparam int PIPE_LATENCY = 49;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS = 1350;
    localparam int SHIFT_SCHED [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    typedef enum logic {ROW_CFG, ROW_DATA} t_row_kind;
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  index;
        logic [63:0] value;
        bit          has_known;
        logic [63:0] known;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_data_block = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_result_block;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    logic [63:0] key_a, key_b, key_c;
    bit          mode_dec, mode_triple;

    logic [63:0] cipher_q [$];
    int          mismatches = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          settings_used = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          cyc = 0;

    des_block_cipher_ede uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sk);
        logic [47:0] e;
        logic [5:0]  six;
        logic [31:0] sy;
        logic [31:0] y;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-T_E[i]];
        e ^= sk;
        for (int s = 0; s < 8; s++) begin
            six = e[47-6*s -: 6];
            sy[31-4*s -: 4] = T_S[s][{six[5], six[0]} * 16 + six[4:1]];
        end
        for (int i = 0; i < 32; i++) y[31-i] = sy[32-T_P[i]];
        return y;
    endfunction

    function automatic logic [63:0] des_pass(input logic [63:0] blk, input logic [63:0] key,
                                             input bit dec);
        logic [55:0] kp;
        logic [27:0] c, d;
        logic [55:0] cd;
        logic [47:0] sk [16];
        logic [63:0] x, y;
        logic [31:0] l, r, t;
        for (int i = 0; i < 56; i++) kp[55-i] = key[64-T_PC1[i]];
        c = kp[55:28];
        d = kp[27:0];
        for (int n = 0; n < 16; n++) begin
            for (int k = 0; k < SHIFT_SCHED[n]; k++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd = {c, d};
            for (int i = 0; i < 48; i++) sk[n][47-i] = cd[56-T_PC2[i]];
        end
        for (int i = 0; i < 64; i++) x[63-i] = blk[64-T_IP[i]];
        l = x[63:32];
        r = x[31:0];
        for (int n = 0; n < 16; n++) begin
            t = r;
            r = l ^ feistel(r, sk[dec ? 15 - n : n]);
            l = t;
        end
        x = {r, l};
        for (int i = 0; i < 64; i++) y[63-i] = x[64-T_FP[i]];
        return y;
    endfunction

    function automatic logic [63:0] predict_cipher(input logic [63:0] blk);
        if (!mode_triple) return des_pass(blk, key_a, mode_dec);
        if (!mode_dec)
            return des_pass(des_pass(des_pass(blk, key_a, 0), key_b, 1), key_c, 0);
        return des_pass(des_pass(des_pass(blk, key_c, 1), key_b, 0), key_a, 1);
    endfunction

    task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("mismatch at word %0d: result_block %h, expected %h", words_out, got, want);
    endtask

    task automatic wait_idle();
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Ends the current burst so no word is offered while the sender is paused.
    task automatic stop_sending();
        i_valid    <= 1'b0;
        burst_left = 0;
    endtask

    // Register writes happen only with the pipeline empty, so the shadow copy
    // can change at once.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        stop_sending();
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (t_reg_index'(idx))
            REG_KEY_ONE:   key_a = val;
            REG_KEY_TWO:   key_b = val;
            REG_KEY_THREE: key_c = val;
            REG_DECRYPT:   mode_dec = val[0];
            REG_TRIPLE:    mode_triple = val[0];
            default: ;
        endcase
        settings_used++;
    endtask

    task automatic send_word(input logic [63:0] blk, input bit has_known,
                             input logic [63:0] known);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_data_block <= blk;
        do @(posedge i_clk); while (!o_ready);
        cipher_q.push_back(has_known ? known : predict_cipher(blk));
        words_in++;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // The receiver cycles through steady, random, periodic and sparse ready.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            case ((cyc / 256) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= ((cyc % 42) < 30);
                default: i_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (cipher_q.size() == 0) begin
                mismatches++;
                $display("unexpected output word %h", o_result_block);
            end else if (o_result_block !== cipher_q[0]) begin
                report_mismatch(o_result_block, cipher_q.pop_front());
            end else begin
                void'(cipher_q.pop_front());
            end
            words_out++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL des_block_cipher_ede");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        int   n;
        int   burst;
        key_a = '0;
        key_b = '0;
        key_c = '0;
        mode_dec = 0;
        mode_triple = 0;

        rows.push_back('{ROW_DATA, 3'd0, 64'h0, 1, 64'h8CA64DE9C1B123A7});
        rows.push_back('{ROW_DATA, 3'd0, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_KEY_ONE, 64'h133457799BBCDFF1, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'h0123456789ABCDEF, 1, 64'h85E813540F0AB405});
        rows.push_back('{ROW_CFG, REG_DECRYPT, 64'h1, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'h85E813540F0AB405, 1, 64'h0123456789ABCDEF});
        // Only bit 0 of a one-bit register counts.
        rows.push_back('{ROW_CFG, REG_DECRYPT, 64'hFFFFFFFFFFFFFFFE, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'h0123456789ABCDEF, 1, 64'h85E813540F0AB405});
        // Writes to unused indexes must leave every register alone.
        rows.push_back('{ROW_CFG, 3'd5, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0});
        rows.push_back('{ROW_CFG, 3'd7, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'h0123456789ABCDEF, 1, 64'h85E813540F0AB405});
        // With three equal keys, EDE collapses to single DES.
        rows.push_back('{ROW_CFG, REG_KEY_TWO, 64'h133457799BBCDFF1, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_KEY_THREE, 64'h133457799BBCDFF1, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_TRIPLE, 64'h1, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'h0123456789ABCDEF, 1, 64'h85E813540F0AB405});
        rows.push_back('{ROW_CFG, REG_KEY_TWO, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_KEY_THREE, 64'h0123456789ABCDEF, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'hDEADBEEFCAFEF00D, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_DECRYPT, 64'h1, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'h0, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_KEY_ONE, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0});
        rows.push_back('{ROW_CFG, REG_TRIPLE, 64'h3, 0, 64'h0});
        rows.push_back('{ROW_DATA, 3'd0, 64'hFFFFFFFFFFFFFFFF, 0, 64'h0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG)
                write_reg(rows[k].index, rows[k].value);
            else
                send_word(rows[k].value, rows[k].has_known, rows[k].known);
        end

        n = 0;
        while (n < RANDOM_WORDS) begin
            write_reg(REG_KEY_ONE, pick_word());
            write_reg(REG_KEY_TWO, pick_word());
            write_reg(REG_KEY_THREE, pick_word());
            write_reg(REG_DECRYPT, {$urandom, $urandom});
            write_reg(REG_TRIPLE, {$urandom, $urandom});
            if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), pick_word());
            burst = $urandom_range(60, 200);
            if (burst > RANDOM_WORDS - n) burst = RANDOM_WORDS - n;
            repeat (burst) begin
                send_word(pick_word(), 0, 64'h0);
                n++;
            end
        end

        stop_sending();
        wait_idle();
        $display("covered %0d words in, %0d words out, %0d register writes",
                 words_in, words_out, settings_used);
        $display("single and triple modes, both directions, extreme and random keys");
        if (mismatches == 0 && cipher_q.size() == 0) begin
            $display("PASS des_block_cipher_ede");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, cipher_q.size());
            $display("FAIL des_block_cipher_ede");
        end
        $finish;
    end

endmodule

[des_block_cipher_ede.f]
+incdir+design
design/des_pkg.sv
design/des_block_cipher_ede.sv
bench/tb_des_block_cipher_ede.sv
